[rtl/core/fm2d_pkg.sv]
// fm2d_pkg: shared types, register indexes and helpers for the interval merger
// used by the channel interfaces, the top level and the port checker
// no dependencies
package fm2d_pkg;

  // default table depth
  localparam int MAX_ENTRIES_DEF = 256;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PVAL_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_HALF  = 2'd2;
  localparam int CFG_DATA_W = 32;

  // result status codes
  typedef enum logic [1:0] {
    ST_REJECT = 2'd0,
    ST_MERGED = 2'd1,
    ST_NEW    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // one interaction
  typedef struct packed {
    logic [7:0]  chrom_a;
    logic [29:0] pos_a;
    logic [7:0]  chrom_b;
    logic [29:0] pos_b;
    logic [31:0] contact_score;
    logic [31:0] p_value;
  } in_item_t;

  // one result
  typedef struct packed {
    status_t     status;
    logic [7:0]  entry_index;
    logic [29:0] entry_start_a;
    logic [30:0] entry_end_a;
    logic [29:0] entry_start_b;
    logic [30:0] entry_end_b;
    logic [31:0] total_seen;
    logic [31:0] total_passed;
    logic [8:0]  entries_used;
  } out_item_t;

  // one table entry as stored in the memory
  typedef struct packed {
    logic [15:0] chroms;
    logic [29:0] start_a;
    logic [30:0] end_a;
    logic [29:0] start_b;
    logic [30:0] end_b;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // saturating increment
  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

[rtl/core/fm2d_if.sv]
// fm2d channel interfaces: interaction input, result output, config write
// depends on fm2d_pkg for payload types and widths
interface fm2d_in_if;
  import fm2d_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fm2d_out_if;
  import fm2d_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface fm2d_cfg_if;
  import fm2d_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/fm2d_ram.sv]
// fm2d_ram: generic single write port, single read port ram with registered read
// no dependencies
module fm2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/filter_merge_2d_intervals.sv]
// filter_merge_2d_intervals: interaction filter and 2-d window merge table
// depends on fm2d_pkg, fm2d_if (channel interfaces) and fm2d_ram
//
// Each accepted interaction is checked against the score and p-value
// thresholds; a kept one becomes two windows pos +/- bin_half_width (start
// clamped at 0) and the entry table, held in one ram, is scanned from entry 0
// for the first entry with the same chromosome pair whose windows strictly
// overlap both new windows. A hit widens that entry, a miss appends a new one,
// and a full table drops the item with status 3. One result beat per input
// beat. The scan covers the entries in use (at most MAX_ENTRIES), reads one
// ram entry per cycle and stops at the first hit; a rejected item skips the
// scan. One item is in work at a time; the result register lets the next
// item be taken while a finished result is still waiting. Config writes are
// always ready and belong to idle periods.
module filter_merge_2d_intervals #(
  parameter int MAX_ENTRIES = fm2d_pkg::MAX_ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  fm2d_in_if.sink    item,
  fm2d_out_if.source result,
  fm2d_cfg_if.sink   cfg
);
  import fm2d_pkg::*;

  localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int FW  = $clog2(MAX_ENTRIES + 1);
  localparam int IXW = (AW > 8) ? AW : 8;
  localparam int FXW = (FW > 9) ? FW : 9;
  localparam logic [FW-1:0] FILL_MAX = FW'(MAX_ENTRIES);

  typedef enum logic [1:0] {S_IDLE, S_CALC, S_SCAN, S_FINISH} state_t;

  state_t      state;
  logic [31:0] score_thr;
  logic [31:0] pval_thr;
  logic [19:0] bin_half;

  in_item_t    cur;
  logic        pass;
  logic [15:0] key;
  logic [29:0] s1, s2;
  logic [30:0] e1, e2;

  logic [FW-1:0] fill;
  logic [31:0]   seen;
  logic [31:0]   passed;

  logic [FW-1:0] scan_addr;
  logic          pend;
  logic [AW-1:0] pend_addr;
  logic          found;
  logic [AW-1:0] hit_addr;
  entry_t        hit;

  logic      out_valid;
  out_item_t out_data;

  // ram ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              rd_entry;

  fm2d_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_addr[AW-1:0]),
    .rdata (ram_rdata)
  );

  // handshake outputs
  assign item.ready   = (state == S_IDLE);
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;

  // threshold test and window bounds for the held item
  logic        pass_c;
  logic [29:0] bh30;
  logic [29:0] s1_c, s2_c;
  logic [30:0] e1_c, e2_c;

  always_comb begin
    bh30   = 30'(bin_half);
    pass_c = (cur.contact_score >= score_thr) && (cur.p_value <= pval_thr);
    s1_c   = (cur.pos_a >= bh30) ? cur.pos_a - bh30 : '0;
    s2_c   = (cur.pos_b >= bh30) ? cur.pos_b - bh30 : '0;
    e1_c   = {1'b0, cur.pos_a} + {1'b0, bh30};
    e2_c   = {1'b0, cur.pos_b} + {1'b0, bh30};
  end

  // overlap test on the entry read last cycle
  logic match_c;
  logic scan_more;

  always_comb begin
    rd_entry  = entry_t'(ram_rdata);
    match_c   = (rd_entry.chroms == key) &&
                ({1'b0, rd_entry.start_a} < e1) && ({1'b0, s1} < rd_entry.end_a) &&
                ({1'b0, rd_entry.start_b} < e2) && ({1'b0, s2} < rd_entry.end_b);
    scan_more = (scan_addr < fill);
    ram_re    = (state == S_SCAN) && !(pend && match_c) && scan_more;
  end

  // update of the touched entry and the result beat
  logic            out_free;
  status_t         res_status;
  entry_t          upd;
  logic [AW-1:0]   res_idx;
  logic [IXW-1:0]  idx_ext;
  logic [FW-1:0]   fill_next;
  logic [FXW-1:0]  fill_ext;
  logic [31:0]     passed_next;
  out_item_t       res;

  always_comb begin
    out_free = !out_valid || result.ready;

    if (!pass) begin
      res_status = ST_REJECT;
    end else if (found) begin
      res_status = ST_MERGED;
    end else if (fill == FILL_MAX) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_NEW;
    end

    upd.chroms  = key;
    upd.start_a = s1;
    upd.end_a   = e1;
    upd.start_b = s2;
    upd.end_b   = e2;
    if (found) begin
      upd.start_a = (s1 < hit.start_a) ? s1 : hit.start_a;
      upd.end_a   = (e1 > hit.end_a)   ? e1 : hit.end_a;
      upd.start_b = (s2 < hit.start_b) ? s2 : hit.start_b;
      upd.end_b   = (e2 > hit.end_b)   ? e2 : hit.end_b;
    end

    res_idx     = found ? hit_addr : fill[AW-1:0];
    fill_next   = (res_status == ST_NEW) ? fill + 1'b1 : fill;
    passed_next = pass ? sat_inc(passed) : passed;

    ram_we    = (state == S_FINISH) && out_free &&
                ((res_status == ST_MERGED) || (res_status == ST_NEW));
    ram_waddr = res_idx;
    ram_wdata = ENTRY_W'(upd);

    idx_ext  = IXW'(res_idx);
    fill_ext = FXW'(fill_next);

    res.status        = res_status;
    res.entry_index   = '0;
    res.entry_start_a = '0;
    res.entry_end_a   = '0;
    res.entry_start_b = '0;
    res.entry_end_b   = '0;
    res.total_seen    = seen;
    res.total_passed  = passed_next;
    res.entries_used  = fill_ext[8:0];
    if ((res_status == ST_MERGED) || (res_status == ST_NEW)) begin
      res.entry_index   = idx_ext[7:0];
      res.entry_start_a = upd.start_a;
      res.entry_end_a   = upd.end_a;
      res.entry_start_b = upd.start_b;
      res.entry_end_b   = upd.end_b;
    end
  end

  // sequencer, config registers, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      score_thr <= '0;
      pval_thr  <= '1;
      bin_half  <= '0;
      fill      <= '0;
      seen      <= '0;
      passed    <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // config beat
      if (cfg.valid) begin
        case (cfg.index)
          CFG_SCORE_THR: score_thr <= cfg.data;
          CFG_PVAL_THR:  pval_thr  <= cfg.data;
          CFG_BIN_HALF:  bin_half  <= cfg.data[19:0];
          default: ;
        endcase
      end

      // result beat loaded, or taken with nothing new behind it
      if ((state == S_FINISH) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (item.valid) begin
            cur   <= item.data;
            seen  <= sat_inc(seen);
            state <= S_CALC;
          end
        end
        S_CALC: begin
          pass      <= pass_c;
          key       <= {cur.chrom_a, cur.chrom_b};
          s1        <= s1_c;
          e1        <= e1_c;
          s2        <= s2_c;
          e2        <= e2_c;
          found     <= 1'b0;
          pend      <= 1'b0;
          scan_addr <= '0;
          state     <= pass_c ? S_SCAN : S_FINISH;
        end
        S_SCAN: begin
          if (pend && match_c) begin
            found    <= 1'b1;
            hit_addr <= pend_addr;
            hit      <= rd_entry;
            pend     <= 1'b0;
            state    <= S_FINISH;
          end else if (scan_more) begin
            pend      <= 1'b1;
            pend_addr <= scan_addr[AW-1:0];
            scan_addr <= scan_addr + 1'b1;
          end else begin
            pend  <= 1'b0;
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_data  <= res;
            fill      <= fill_next;
            passed    <= passed_next;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/core/fm2d_chk.sv]
// fm2d_chk: port-level checks on the interval merger, bound to the top level
// depends on fm2d_pkg and filter_merge_2d_intervals
module fm2d_chk (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_ready,
  input logic                res_valid,
  input logic                res_ready,
  input fm2d_pkg::out_item_t res_data
);
  import fm2d_pkg::*;

  // a stalled result beat holds its payload
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("result beat changed while stalled");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input taken while an item is in work");

  // passed count never runs ahead of seen count
  a_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.total_passed <= res_data.total_seen)
    else $error("total_passed above total_seen");

  // rejected or dropped beats carry no entry
  a_no_entry: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_REJECT || res_data.status == ST_FULL) |->
      res_data.entry_index == '0 && res_data.entry_start_a == '0 &&
      res_data.entry_end_a == '0 && res_data.entry_start_b == '0 &&
      res_data.entry_end_b == '0)
    else $error("entry fields set on a rejected or dropped beat");

  // touched entry windows are well formed
  a_window: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_data.status == ST_MERGED || res_data.status == ST_NEW) |->
      {1'b0, res_data.entry_start_a} <= res_data.entry_end_a &&
      {1'b0, res_data.entry_start_b} <= res_data.entry_end_b)
    else $error("window start above window end");

endmodule

bind filter_merge_2d_intervals fm2d_chk u_fm2d_chk (
  .clk        (clk),
  .rst        (rst),
  .item_valid (item.valid),
  .item_ready (item.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_data   (result.data)
);

[tb/tb_filter_merge_2d_intervals.sv]
// tb_filter_merge_2d_intervals: self-checking bench for the interaction filter and window merge table
// depends on fm2d_pkg, the fm2d channel interfaces and filter_merge_2d_intervals
// a behavioral table model predicts one result per interaction beat, checked field by field
module tb_filter_merge_2d_intervals;
  timeunit 1ns;
  timeprecision 1ps;

  import fm2d_pkg::*;

  localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [29:0] POS_MAX = 30'h3FFF_FFFF;
  localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic clk = 1'b0;
  logic rst;

  fm2d_in_if  in_ch();
  fm2d_out_if res_ch();
  fm2d_cfg_if cfg_ch();

  filter_merge_2d_intervals #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (in_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // model copy of the registers
  logic [31:0] thr_score = 32'd0;
  logic [31:0] thr_pval  = WORD_MAX;
  logic [19:0] half_bin  = 20'd0;

  // model copy of the merge table and counters
  logic [15:0] tbl_key [TABLE_DEPTH];
  logic [29:0] tbl_sa  [TABLE_DEPTH];
  logic [30:0] tbl_ea  [TABLE_DEPTH];
  logic [29:0] tbl_sb  [TABLE_DEPTH];
  logic [30:0] tbl_eb  [TABLE_DEPTH];
  int          fill_cnt = 0;
  logic [31:0] seen_cnt = 32'd0;
  logic [31:0] passed_cnt = 32'd0;

  in_item_t  interaction_q [$];
  out_item_t merge_result_q [$];
  out_item_t expected_merge;

  int items_issued = 0;
  int results_done = 0;
  int error_cnt = 0;
  int cycle_cnt = 0;

  bit beat_taken = 1'b0;
  int burst_left = 1;
  int gap_left = 0;
  logic [31:0] stall_pat = WORD_MAX;
  int pat_age = 0;

  logic [29:0] anchor_a [4];
  logic [29:0] anchor_b [4];

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // filter, search and widen/append, as the block does for one interaction
  function automatic out_item_t merge_interaction(input in_item_t it);
    out_item_t r;
    logic [29:0] s1, s2;
    logic [30:0] e1, e2;
    logic [29:0] hb;
    logic [15:0] key;
    int hit;
    int i;
    r = '0;
    hit = -1;
    hb = 30'(half_bin);
    if (seen_cnt != WORD_MAX) seen_cnt = seen_cnt + 32'd1;
    if (it.contact_score >= thr_score && it.p_value <= thr_pval) begin
      if (passed_cnt != WORD_MAX) passed_cnt = passed_cnt + 32'd1;
      s1 = (it.pos_a >= hb) ? it.pos_a - hb : 30'd0;
      s2 = (it.pos_b >= hb) ? it.pos_b - hb : 30'd0;
      e1 = {1'b0, it.pos_a} + {1'b0, hb};
      e2 = {1'b0, it.pos_b} + {1'b0, hb};
      key = {it.chrom_a, it.chrom_b};
      // first entry that overlaps strictly on both windows
      for (i = 0; i < fill_cnt; i++) begin
        if (hit < 0 && tbl_key[i] == key && {1'b0, tbl_sa[i]} < e1 &&
            {1'b0, s1} < tbl_ea[i] && {1'b0, tbl_sb[i]} < e2 &&
            {1'b0, s2} < tbl_eb[i]) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        if (s1 < tbl_sa[hit]) tbl_sa[hit] = s1;
        if (e1 > tbl_ea[hit]) tbl_ea[hit] = e1;
        if (s2 < tbl_sb[hit]) tbl_sb[hit] = s2;
        if (e2 > tbl_eb[hit]) tbl_eb[hit] = e2;
        r.status = ST_MERGED;
      end else if (fill_cnt < TABLE_DEPTH) begin
        hit = fill_cnt;
        tbl_key[hit] = key;
        tbl_sa[hit] = s1;
        tbl_ea[hit] = e1;
        tbl_sb[hit] = s2;
        tbl_eb[hit] = e2;
        fill_cnt++;
        r.status = ST_NEW;
      end else begin
        r.status = ST_FULL;
      end
      if (r.status == ST_MERGED || r.status == ST_NEW) begin
        r.entry_index = 8'(hit);
        r.entry_start_a = tbl_sa[hit];
        r.entry_end_a = tbl_ea[hit];
        r.entry_start_b = tbl_sb[hit];
        r.entry_end_b = tbl_eb[hit];
      end
    end
    r.total_seen = seen_cnt;
    r.total_passed = passed_cnt;
    r.entries_used = 9'(fill_cnt);
    return r;
  endfunction

  // interaction that passes the current thresholds; clustered or scattered
  function automatic in_item_t make_interaction(input bit scattered);
    in_item_t it;
    logic [31:0] spread, pa, pb;
    if (scattered) begin
      it.chrom_a = 8'($urandom);
      it.chrom_b = 8'($urandom);
      it.pos_a = 30'($urandom);
      it.pos_b = 30'($urandom);
    end else begin
      spread = {9'd0, half_bin, 3'b000} + 32'd16;
      it.chrom_a = 8'($urandom_range(1, 3));
      it.chrom_b = 8'($urandom_range(1, 3));
      pa = {2'b00, anchor_a[$urandom_range(0, 3)]} + $urandom_range(spread, 0);
      pb = {2'b00, anchor_b[$urandom_range(0, 3)]} + $urandom_range(spread, 0);
      if (pa > {2'b00, POS_MAX}) pa = {2'b00, POS_MAX};
      if (pb > {2'b00, POS_MAX}) pb = {2'b00, POS_MAX};
      it.pos_a = pa[29:0];
      it.pos_b = pb[29:0];
    end
    it.contact_score = $urandom_range(WORD_MAX, thr_score);
    it.p_value = $urandom_range(thr_pval, 0);
    return it;
  endfunction

  // random fields, or a near miss on one threshold
  function automatic in_item_t noise_interaction();
    in_item_t it;
    it = make_interaction(1'($urandom_range(0, 1)));
    case ($urandom_range(0, 2))
      0: begin
        it.contact_score = $urandom;
        it.p_value = $urandom;
      end
      1: begin
        if (thr_score != 32'd0) it.contact_score = thr_score - 32'd1;
        else it.p_value = $urandom;
      end
      default: begin
        if (thr_pval != WORD_MAX) it.p_value = thr_pval + 32'd1;
        else it.contact_score = $urandom;
      end
    endcase
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    interaction_q = {interaction_q, it};
    items_issued++;
  endtask

  task automatic send_fields(input logic [7:0] ca, input logic [29:0] pa, input logic [7:0] cb,
                             input logic [29:0] pb, input logic [31:0] score,
                             input logic [31:0] pval);
    in_item_t it;
    it.chrom_a = ca;
    it.pos_a = pa;
    it.chrom_b = cb;
    it.pos_b = pb;
    it.contact_score = score;
    it.p_value = pval;
    send_item(it);
  endtask

  // wait for every outstanding result, then a few idle cycles
  task automatic settle();
    do @(negedge clk); while (results_done != items_issued);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CFG_SCORE_THR: thr_score = val;
      CFG_PVAL_THR:  thr_pval = val;
      CFG_BIN_HALF:  half_bin = val[19:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_filter(input logic [31:0] score, input logic [31:0] pval,
                            input logic [31:0] bin);
    write_reg(CFG_SCORE_THR, score);
    write_reg(CFG_PVAL_THR, pval);
    write_reg(CFG_BIN_HALF, bin);
  endtask

  // mostly clustered interactions that merge, the rest noise
  task automatic random_phase(input int n);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) send_item(make_interaction(1'b0));
      else send_item(noise_interaction());
    end
    settle();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_cnt++;
    end
  endtask

  // interaction driver: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || beat_taken) begin
      beat_taken = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (interaction_q.size() > 0) begin
        in_ch.data <= interaction_q.pop_front();
        in_ch.valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // interaction beats feed the model
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      merge_result_q = {merge_result_q, merge_interaction(in_ch.data)};
      beat_taken = 1'b1;
    end
  end

  // result receiver: rotating stall pattern, sometimes always ready
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[31:1]};
      pat_age++;
      if (pat_age >= 200) begin
        pat_age = 0;
        stall_pat = ($urandom_range(0, 2) == 0) ? WORD_MAX : ($urandom | 32'd1);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && res_ch.valid && res_ch.ready) begin
      results_done++;
      if (merge_result_q.size() == 0) begin
        $error("result beat with no interaction outstanding");
        error_cnt++;
      end else begin
        expected_merge = merge_result_q.pop_front();
        check_field("status", 32'(expected_merge.status), 32'(res_ch.data.status));
        check_field("entry_index", 32'(expected_merge.entry_index),
                    32'(res_ch.data.entry_index));
        check_field("entry_start_a", 32'(expected_merge.entry_start_a),
                    32'(res_ch.data.entry_start_a));
        check_field("entry_end_a", 32'(expected_merge.entry_end_a),
                    32'(res_ch.data.entry_end_a));
        check_field("entry_start_b", 32'(expected_merge.entry_start_b),
                    32'(res_ch.data.entry_start_b));
        check_field("entry_end_b", 32'(expected_merge.entry_end_b),
                    32'(res_ch.data.entry_end_b));
        check_field("total_seen", expected_merge.total_seen, res_ch.data.total_seen);
        check_field("total_passed", expected_merge.total_passed, res_ch.data.total_passed);
        check_field("entries_used", 32'(expected_merge.entries_used),
                    32'(res_ch.data.entries_used));
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // stimulus sequence
  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: everything passes, zero-width windows never overlap
    send_fields(8'd0, 30'd0, 8'd0, 30'd0, 32'd0, 32'd0);
    send_fields(8'd0, 30'd0, 8'd0, 30'd0, 32'd0, 32'd0);
    send_fields(8'd255, POS_MAX, 8'd255, POS_MAX, WORD_MAX, WORD_MAX);
    send_fields(8'd255, 30'd0, 8'd0, POS_MAX, 32'd0, WORD_MAX);
    settle();

    // unknown index is ignored, bin half width keeps its low 20 bits
    write_reg(CFG_UNUSED_IDX, WORD_MAX);
    set_filter(32'h0001_0000, 32'h8000_0000, 32'hFFF0_0400);

    // threshold edges, merge, touching windows, swapped pair, clamping
    send_fields(8'd1, 30'd5000, 8'd2, 30'd9000, 32'h0000_FFFF, 32'd0);
    send_fields(8'd1, 30'd5000, 8'd2, 30'd9000, 32'h0001_0000, 32'h8000_0000);
    send_fields(8'd1, 30'd5000, 8'd2, 30'd9000, WORD_MAX, 32'h8000_0001);
    send_fields(8'd1, 30'd5500, 8'd2, 30'd9500, 32'h0002_0000, 32'd0);
    send_fields(8'd1, 30'd5500, 8'd2, 30'd20000, 32'h0002_0000, 32'd0);
    send_fields(8'd2, 30'd5000, 8'd1, 30'd9000, 32'h0002_0000, 32'd0);
    send_fields(8'd1, 30'd7548, 8'd2, 30'd9000, 32'h0002_0000, 32'd0);
    send_fields(8'd1, 30'd7547, 8'd2, 30'd9000, 32'h0002_0000, 32'd0);
    send_fields(8'd3, 30'd0, 8'd3, 30'd100, 32'h0002_0000, 32'd0);
    send_fields(8'd3, POS_MAX, 8'd3, POS_MAX, 32'h0002_0000, 32'd0);
    settle();

    // tightest thresholds, widest windows
    set_filter(WORD_MAX, 32'd0, 32'h000F_FFFF);
    send_fields(8'd4, 30'd0, 8'd4, 30'd0, WORD_MAX, 32'd0);
    send_fields(8'd4, 30'd0, 8'd4, 30'd0, 32'hFFFF_FFFE, 32'd0);
    send_fields(8'd4, 30'd0, 8'd4, 30'd0, WORD_MAX, 32'd1);
    send_fields(8'd4, POS_MAX, 8'd4, POS_MAX, WORD_MAX, 32'd0);
    send_fields(8'd4, 30'h0010_0000, 8'd4, 30'h0010_0000, WORD_MAX, 32'd0);
    settle();

    // cluster centers at both ends of the position range and at random points
    anchor_a[0] = 30'd0;
    anchor_b[0] = 30'd0;
    anchor_a[1] = 30'($urandom);
    anchor_b[1] = 30'($urandom);
    anchor_a[2] = POS_MAX - 30'($urandom_range(0, 1000));
    anchor_b[2] = POS_MAX - 30'($urandom_range(0, 1000));
    anchor_a[3] = 30'($urandom);
    anchor_b[3] = 30'($urandom);

    set_filter(32'd0, WORD_MAX, $urandom_range(2048, 64));
    random_phase(150);
    random_phase(150);
    set_filter($urandom, $urandom, $urandom_range(4096, 16));
    random_phase(300);
    set_filter(32'h0001_0000, 32'h8000_0000, 32'd0);
    random_phase(200);
    set_filter($urandom_range(32'h0100_0000, 0), $urandom_range(WORD_MAX, 32'h4000_0000),
               32'h000F_FFFF);
    random_phase(200);

    // fill the table with scattered pairs until it is full
    while (fill_cnt < TABLE_DEPTH) begin
      repeat (TABLE_DEPTH - fill_cnt) send_item(make_interaction(1'b1));
      settle();
    end

    // full table: merges, drops and rejects
    set_filter($urandom, $urandom, $urandom_range(4096, 16));
    random_phase(250);
    set_filter(32'd0, WORD_MAX, $urandom_range(2048, 64));
    random_phase(250);

    // any late result beat is flagged by the monitor
    repeat (TABLE_DEPTH + 40) @(negedge clk);
    if (error_cnt == 0 && merge_result_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/fm2d_pkg.sv
rtl/core/fm2d_if.sv
rtl/core/fm2d_ram.sv
rtl/core/filter_merge_2d_intervals.sv
rtl/core/fm2d_chk.sv
tb/tb_filter_merge_2d_intervals.sv
